@@ rtl/core/ttafd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttafd_pkg: shared types and constants for the two-tap ADPCM frame decoder
// Input and output words, the command word between front and back, codes.
// ----------------------------------------------------------------------------
package ttafd_pkg;

    // frame geometry
    localparam int CODES_PER_FRAME = 14;
    localparam int IDX_W           = $clog2(CODES_PER_FRAME);
    localparam int CODES_W         = 4 * CODES_PER_FRAME;

    // item kinds
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_COEF_LO     = 3'd0;
    localparam logic [2:0] CFG_COEF_MID_LO = 3'd1;
    localparam logic [2:0] CFG_COEF_MID_HI = 3'd2;
    localparam logic [2:0] CFG_COEF_HI     = 3'd3;
    localparam logic [2:0] CFG_HIST_NEWER  = 3'd4;
    localparam logic [2:0] CFG_HIST_OLDER  = 3'd5;
    localparam logic [2:0] CFG_LIMIT       = 3'd6;

    // command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // input word
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         frame_header;
        logic [CODES_W-1:0] frame_codes;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               run_last;
        logic               channel_done;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         shift;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic [CODES_W-1:0] codes;
    } t_cmd;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/core/ttafd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttafd_front: input acceptance and item classification
// Picks the coefficient pair and scale shift and forms a command word.
// ----------------------------------------------------------------------------
module ttafd_front (
    input  ttafd_pkg::t_in_word     i_in_word,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [3:0][63:0]        i_coef,
    input  ttafd_pkg::t_q_status    i_q_status,
    output logic                    o_push,
    output ttafd_pkg::t_cmd         o_cmd
);
    import ttafd_pkg::*;

    logic [3:0]  w_pred;
    logic [63:0] w_reg;
    logic        w_keep;

    // stall only on a full queue; kind three is taken and dropped
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full && w_keep;

    // predictor select, out-of-range indexes fall back to pair 0
    always_comb begin
        w_pred = i_in_word.frame_header[7:4];
        if (w_pred[3]) begin
            w_pred = 4'd0;
        end
        w_reg = i_coef[w_pred[2:1]];
    end

    // decode kind
    always_comb begin
        unique case (i_in_word.kind)
            KIND_FRAME, KIND_PAD, KIND_RESTART: w_keep = 1'b1;
            default:                            w_keep = 1'b0;
        endcase
    end

    // command word
    always_comb begin
        o_cmd.op    = i_in_word.kind;
        o_cmd.shift = i_in_word.frame_header[3:0];
        o_cmd.c1    = w_pred[0] ? w_reg[47:32] : w_reg[15:0];
        o_cmd.c2    = w_pred[0] ? w_reg[63:48] : w_reg[31:16];
        o_cmd.codes = i_in_word.frame_codes;
    end

endmodule

@@ rtl/core/ttafd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttafd_queue: short command queue between front and back
// Lets the front take a new item while the back is still decoding.
// ----------------------------------------------------------------------------
module ttafd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  ttafd_pkg::t_cmd         i_cmd,
    input  logic                    i_pop,
    output ttafd_pkg::t_cmd         o_cmd,
    output ttafd_pkg::t_q_status    o_status
);
    import ttafd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_status.full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/ttafd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttafd_back: sample sequencer with history, count and output register
// Runs one command at a time; frame samples go through S_MUL, then S_ACC.
// ----------------------------------------------------------------------------
module ttafd_back #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ttafd_pkg::t_cmd         i_cmd,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_pop,
    input  logic signed [15:0]      i_start_newer,
    input  logic signed [15:0]      i_start_older,
    input  logic [COUNT_WIDTH-1:0]  i_limit,
    output ttafd_pkg::t_out_word    o_out_word,
    output logic                    o_out_valid,
    input  logic                    i_out_stall
);
    import ttafd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    localparam logic [1:0] S_PAD  = 2'd3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODES_PER_FRAME - 1);

    logic [1:0]             r_state;
    logic [COUNT_WIDTH:0]   r_cnt;
    logic [IDX_W-1:0]       r_idx;
    logic signed [15:0]     r_hn;
    logic signed [15:0]     r_ho;
    logic signed [15:0]     r_c1;
    logic signed [15:0]     r_c2;
    logic [3:0]             r_shift;
    logic [CODES_W-1:0]     r_codes;
    logic signed [31:0]     r_p1;
    logic signed [31:0]     r_p2;
    t_out_word              r_out_word;
    logic                   r_out_valid;

    logic                   w_below;
    logic                   w_free;
    logic                   w_emit;
    logic [COUNT_WIDTH:0]   w_cnt_inc;
    logic                   w_done;
    logic                   w_last;
    logic [33:0]            w_code_term;
    logic [4:0]             w_shamt;
    logic signed [33:0]     w_sum;
    logic signed [22:0]     w_q;
    logic signed [15:0]     w_sample;

    assign o_out_word  = r_out_word;
    assign o_out_valid = r_out_valid;

    // control terms
    always_comb begin
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        w_below   = r_cnt < {1'b0, i_limit};
        w_free    = !r_out_valid || !i_out_stall;
        w_emit    = ((r_state == S_ACC) || (r_state == S_PAD)) && w_free;
        w_cnt_inc = r_cnt + 1'b1;
        w_done    = (w_cnt_inc == {1'b0, i_limit});
        w_last    = (r_idx == LAST_IDX) || w_done;
    end

    // sample: floor((code << (shift+11)) + 1024 + p1 + p2) / 2048, saturated
    always_comb begin
        w_shamt     = {1'b0, r_shift} + 5'd11;
        w_code_term = {{30{r_codes[CODES_W-1]}}, r_codes[CODES_W-1 -: 4]} << w_shamt;
        w_sum       = $signed(w_code_term) + 34'sd1024
                    + {{2{r_p1[31]}}, r_p1} + {{2{r_p2[31]}}, r_p2};
        w_q         = w_sum[33:11];
        if (w_q > 23'sd32767) begin
            w_sample = 16'sh7FFF;
        end else if (w_q < -23'sd32768) begin
            w_sample = 16'sh8000;
        end else begin
            w_sample = w_q[15:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_hn        <= '0;
            r_ho        <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        case (i_cmd.op)
                            KIND_RESTART: begin
                                r_hn  <= i_start_newer;
                                r_ho  <= i_start_older;
                                r_cnt <= '0;
                            end
                            KIND_FRAME: begin
                                if (w_below) begin
                                    r_state <= S_MUL;
                                end
                            end
                            KIND_PAD: begin
                                if (w_below) begin
                                    r_state <= S_PAD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_free) begin
                        r_hn    <= w_sample;
                        r_ho    <= r_hn;
                        r_cnt   <= w_cnt_inc;
                        r_state <= w_last ? S_IDLE : S_MUL;
                    end
                end
                S_PAD: begin
                    if (w_free) begin
                        r_cnt   <= w_cnt_inc;
                        r_state <= w_last ? S_IDLE : S_PAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_idx   <= '0;
            r_c1    <= i_cmd.c1;
            r_c2    <= i_cmd.c2;
            r_shift <= i_cmd.shift;
            r_codes <= i_cmd.codes;
        end else if (w_emit) begin
            r_idx   <= r_idx + 1'b1;
            r_codes <= {r_codes[CODES_W-5:0], 4'b0000};
        end
        if (r_state == S_MUL) begin
            r_p1 <= r_c1 * r_hn;
            r_p2 <= r_c2 * r_ho;
        end
        if (w_emit) begin
            r_out_word.pcm_sample   <= (r_state == S_ACC) ? w_sample : 16'sd0;
            r_out_word.run_last     <= w_last;
            r_out_word.channel_done <= w_done;
        end
    end

endmodule

@@ rtl/core/two_tap_adpcm_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tap_adpcm_frame_decoder: 4-bit two-tap predictive ADPCM decoder
// Config registers, front classifier, command queue and sample sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  Input words (frame, pad, restart) enter on i_in_valid / o_in_stall. A word
//  is taken on any edge with valid high and stall low; stall rises only when
//  the two-entry command queue is full.
//  Decoded samples leave on o_out_valid / i_out_stall from one output
//  register; while the receiver stalls, the word holds and the sequencer
//  waits with its history unchanged.
//  Registers are written on i_cfg_valid with o_cfg_ready, which is always
//  high; write them only while the decoder is idle.
//  Sequencing: a frame passes each sample through a multiply state, then an
//  accumulate-and-saturate state, a loop closed through the sample history;
//  a pad emits its zero samples from one state; a restart, or a frame or pad
//  past the limit, is finished in the idle state of the sequencer; a kind
//  three word is dropped at the input.
//  Reset (synchronous, active low) clears registers, history, sample count,
//  the queue and the output valid flag.
// ----------------------------------------------------------------------------
module two_tap_adpcm_frame_decoder #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ttafd_pkg::t_in_word     i_in_word,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    output ttafd_pkg::t_out_word    o_out_word,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data
);
    import ttafd_pkg::*;

    logic [3:0][63:0]       r_coef;
    logic signed [15:0]     r_start_newer;
    logic signed [15:0]     r_start_older;
    logic [COUNT_WIDTH-1:0] r_limit;

    t_cmd       w_front_cmd;
    t_cmd       w_q_cmd;
    t_q_status  w_q_status;
    logic       w_push;
    logic       w_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef        <= '0;
            r_start_newer <= '0;
            r_start_older <= '0;
            r_limit       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COEF_LO:     r_coef[0]     <= i_cfg_data;
                CFG_COEF_MID_LO: r_coef[1]     <= i_cfg_data;
                CFG_COEF_MID_HI: r_coef[2]     <= i_cfg_data;
                CFG_COEF_HI:     r_coef[3]     <= i_cfg_data;
                CFG_HIST_NEWER:  r_start_newer <= i_cfg_data[15:0];
                CFG_HIST_OLDER:  r_start_older <= i_cfg_data[15:0];
                CFG_LIMIT:       r_limit       <= i_cfg_data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    ttafd_front u_front (
        .i_in_word  (i_in_word),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_coef     (r_coef),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    // command queue
    ttafd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_q_cmd),
        .o_status (w_q_status)
    );

    // back: sample sequencer
    ttafd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_q_cmd),
        .i_cmd_valid   (!w_q_status.empty),
        .o_cmd_pop     (w_pop),
        .i_start_newer (r_start_newer),
        .i_start_older (r_start_older),
        .i_limit       (r_limit),
        .o_out_word    (o_out_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall)
    );

    // a sample that reaches the limit always closes its item's run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.channel_done |-> o_out_word.run_last)
        else $error("channel_done without run_last");

    // a full queue must hold off the input side
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> o_in_stall && !w_push && !w_q_status.empty)
        else $error("push into full command queue");

    // the back never pops an empty queue
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty command queue");

endmodule
